@@ src/fal_pkg.sv @@
// ----------------------------------------------------------------------------
// fal_pkg
// Shared types and constants for the fixed array list: operation and status
// codes, list sizing and the transaction structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package fal_pkg;

  // list sizing
  localparam int CAPACITY = 16;
  localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;

  // width wide enough to compare an index against the count
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_FIND   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_CHANGE = 3'd2;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd3;

  typedef struct packed {
    logic        [FUNC_W-1:0] func;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
    logic        [IDX_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    logic        [STATUS_W-1:0]  status;
    logic        [IDX_W-1:0]     position;
    logic signed [DATA_W-1:0]    entry_value;
    logic        [OUT_CNT_W-1:0] count;
  } out_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     apply;
    logic                     ins_ok;
    logic        [FUNC_W-1:0] func;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
    logic        [CMP_W-1:0]  ins_pos;
    logic        [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/fal_cell.sv @@
// ----------------------------------------------------------------------------
// fal_cell
// One list slot: holds an entry, compares it against the search value,
// passes the first-match chain on and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module fal_cell (
  input  wire logic                             clk,
  input  wire logic [fal_pkg::POS_W-1:0]        cell_idx,
  input  wire fal_pkg::cell_ctrl_t              ctrl,
  input  wire logic signed [fal_pkg::DATA_W-1:0] left_entry,
  input  wire logic signed [fal_pkg::DATA_W-1:0] right_entry,
  input  wire logic                             hit_in,
  output logic                                  hit_out,
  output logic                                  first_hit,
  output logic signed [fal_pkg::DATA_W-1:0]     entry
);
  import fal_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     used;
  logic                     match;
  logic [CMP_W-1:0]         my_pos;

  // compare against the search value, only over used slots
  assign my_pos    = CMP_W'(cell_idx);
  assign used      = CNT_W'(cell_idx) < ctrl.count;
  assign match     = used && (entry_r == ctrl.value);
  assign hit_out   = hit_in | match;
  assign first_hit = match & ~hit_in;
  assign entry     = entry_r;

  // local update: insert shifts up, remove shifts down, change rewrites
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.apply) begin
      case (ctrl.func)
        OP_INSERT: begin
          if (ctrl.ins_ok) begin
            if (my_pos > ctrl.ins_pos) begin
              entry_nxt = left_entry;
            end else if (my_pos == ctrl.ins_pos) begin
              entry_nxt = ctrl.value;
            end
          end
        end
        OP_CHANGE: begin
          if (first_hit) begin
            entry_nxt = ctrl.new_value;
          end
        end
        OP_REMOVE: begin
          if (hit_out) begin
            entry_nxt = right_entry;
          end
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

@@ src/fixed_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_array_list_unit
// Ordered list of signed 32-bit values kept in a row of cells, with insert,
// find, change, remove and read-at-index operations.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   the request travels in in_item (func, value, new_value, index).
//   busy rises for the cycle after acceptance, in which all cells compare
//   the request in parallel, the first-match chain ripples through the row
//   and the cells shift or rewrite together at its closing edge.
//   The result appears in out_item with out_valid high for exactly one cycle,
//   registered at the end of the busy cycle; the receiver cannot stall it.
//   A new transaction may be accepted in that same result cycle, but not
//   while busy, since the compare-and-shift pass across the cell row must
//   finish first.
//   Reset (rst_n low at a clock edge) empties the list and clears busy and
//   out_valid; entry contents are left as they are and never read before
//   being written.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_array_list_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire fal_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output fal_pkg::out_item_t      out_item
);
  import fal_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  in_item_t   req_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  out_item_t  out_r;
  out_item_t  out_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  cell_ctrl_t ctrl;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY:0]        hit_chain;
  logic [CAPACITY-1:0]      first_vec;

  logic             full;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] ins_pos;
  logic             read_ok;
  logic [POS_W-1:0] hit_pos;
  logic signed [DATA_W-1:0] rd_value;

  // request decode
  assign full    = count_r >= CNT_W'(CAPACITY);
  assign idx_ext = CMP_W'(req_r.index);
  assign cnt_ext = CMP_W'(count_r);
  assign ins_pos = (idx_ext < cnt_ext) ? idx_ext : cnt_ext;
  assign read_ok = idx_ext < cnt_ext;

  // broadcast to the cell row
  always_comb begin
    ctrl.apply     = (state_r == S_EXEC);
    ctrl.ins_ok    = ~full;
    ctrl.func      = req_r.func;
    ctrl.value     = req_r.value;
    ctrl.new_value = req_r.new_value;
    ctrl.ins_pos   = ins_pos;
    ctrl.count     = count_r;
  end

  // cell row
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_e;
    logic signed [DATA_W-1:0] right_e;

    if (i == 0) begin : g_left_edge
      assign left_e = req_r.value;
    end else begin : g_left
      assign left_e = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign right_e = entries[i];
    end else begin : g_right
      assign right_e = entries[i+1];
    end

    fal_cell u_cell (
      .clk         (clk),
      .cell_idx    (POS_W'(i)),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .first_hit   (first_vec[i]),
      .entry       (entries[i])
    );
  end

  // encode the first match and select the read entry
  always_comb begin
    hit_pos  = '0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
      if (idx_ext == CMP_W'(i)) begin
        rd_value = rd_value | entries[i];
      end
    end
  end

  // result and count update
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt            = S_IDLE;
        out_valid_nxt        = 1'b1;
        out_nxt.status       = ST_OK;
        out_nxt.position     = '0;
        out_nxt.entry_value  = '0;
        case (req_r.func)
          OP_INSERT: begin
            if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              out_nxt.position = ins_pos[IDX_W-1:0];
              count_nxt        = count_r + CNT_W'(1);
            end
          end
          OP_FIND, OP_CHANGE: begin
            if (hit_chain[CAPACITY]) begin
              out_nxt.position = IDX_W'(hit_pos);
            end else begin
              out_nxt.status = ST_MISSING;
            end
          end
          OP_REMOVE: begin
            if (hit_chain[CAPACITY]) begin
              out_nxt.position = IDX_W'(hit_pos);
              count_nxt        = count_r - CNT_W'(1);
            end else begin
              out_nxt.status = ST_MISSING;
            end
          end
          OP_READ: begin
            if (read_ok) begin
              out_nxt.position    = req_r.index;
              out_nxt.entry_value = rd_value;
            end else begin
              out_nxt.status = ST_BEYOND;
            end
          end
          default: begin
            out_nxt.status = ST_OK;
          end
        endcase
        out_nxt.count = OUT_CNT_W'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == S_IDLE && start) begin
      req_r <= in_item;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

@@ dv/fal_list_checker.sv @@
// ----------------------------------------------------------------------------
// fal_list_checker
// Watches both channels of the fixed array list. It keeps its own copy of
// the list and its count, works out the reply to each accepted transaction
// and compares every reply, field by field, with the oldest one awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fal_list_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  fal_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  fal_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  import fal_pkg::*;

  localparam int REPORT_MAX = 10;

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_len;

  // replies still owed by the block, oldest first
  out_item_t awaited_replies [$];

  // apply one operation to the shadow list and return the reply it gives
  function automatic out_item_t list_op_effect(input in_item_t req);
    out_item_t rsp;
    int        slot;
    int        hit;
    int        i;
    rsp = '0;
    case (req.func)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          // an index at or past the count appends
          slot = (int'(req.index) < list_len) ? int'(req.index) : list_len;
          for (i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
          list_vals[slot] = req.value;
          list_len++;
          rsp.position = slot[IDX_W-1:0];
        end
      end
      OP_FIND, OP_CHANGE, OP_REMOVE: begin
        // first match among the entries in use
        hit = -1;
        for (i = 0; i < list_len; i++) begin
          if (hit < 0 && list_vals[i] == req.value) hit = i;
        end
        if (hit < 0) begin
          rsp.status = ST_MISSING;
        end else begin
          rsp.position = hit[IDX_W-1:0];
          if (req.func == OP_CHANGE) begin
            list_vals[hit] = req.new_value;
          end else if (req.func == OP_REMOVE) begin
            for (i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
            list_len--;
          end
        end
      end
      OP_READ: begin
        if (int'(req.index) < list_len) begin
          rsp.position    = req.index;
          rsp.entry_value = list_vals[req.index];
        end else begin
          rsp.status = ST_BEYOND;
        end
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
    rsp.count = list_len[OUT_CNT_W-1:0];
    return rsp;
  endfunction

  // compare replies first, then queue the reply of a newly accepted transaction
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      awaited_replies.delete();
      list_len   = 0;
      fail_count = 0;
      checked    = 0;
    end else begin
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("[%0t] reply with nothing awaited: status=%0d pos=%0d value=%0d count=%0d",
                     $realtime, out_item.status, out_item.position,
                     out_item.entry_value, out_item.count);
        end else begin
          want = awaited_replies.pop_front();
          checked++;
          if (out_item.status      !== want.status   ||
              out_item.position    !== want.position ||
              out_item.entry_value !== want.entry_value ||
              out_item.count       !== want.count) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"[%0t] reply %0d mismatch: exp status=%0d pos=%0d value=%0d count=%0d",
                        " / got status=%0d pos=%0d value=%0d count=%0d"},
                       $realtime, checked, want.status, want.position,
                       want.entry_value, want.count, out_item.status,
                       out_item.position, out_item.entry_value, out_item.count);
          end
        end
      end
      if (start && !busy) awaited_replies.push_back(list_op_effect(in_item));
    end
    pending = awaited_replies.size();
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the fixed array list with a short directed sequence covering an empty
// list, field extremes, misses, duplicates and unused codes, then with fill,
// drain and mixed phases of random transactions sent in bursts.
// The checker beside the block predicts and compares; this module judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import fal_pkg::*;

  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [FUNC_W-1:0]      OP_LAST_CODE = '1;
  localparam logic signed [DATA_W-1:0] VAL_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_ABSENT = 32'sd777;

  // phase flavors of the random part
  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int checked;
  int burst_left;
  int idle_run;
  int op_tally [1 << FUNC_W];

  logic signed [DATA_W-1:0] value_pool [6];

  always #6 clk = ~clk;

  fixed_array_list_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  fal_list_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_run);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic in_item_t mk(input logic [FUNC_W-1:0] f,
                                  input logic signed [DATA_W-1:0] v,
                                  input logic signed [DATA_W-1:0] nv,
                                  input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.func      = f;
    it.value     = v;
    it.new_value = nv;
    it.index     = idx;
    return it;
  endfunction

  // mostly values from a small pool so searches hit, sometimes anything
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic in_item_t random_item(input phase_kind_t kind);
    in_item_t it;
    int       r;
    r            = $urandom_range(0, 99);
    it.value     = pick_value();
    it.new_value = pick_value();
    it.index     = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    case (kind)
      PH_FILL:
        it.func = (r < 80) ? OP_INSERT : (r < 86) ? OP_FIND : (r < 92) ? OP_CHANGE :
                  (r < 97) ? OP_READ : OP_REMOVE;
      PH_DRAIN:
        it.func = (r < 15) ? OP_INSERT : (r < 70) ? OP_REMOVE : (r < 80) ? OP_FIND :
                  (r < 88) ? OP_CHANGE : OP_READ;
      default:
        it.func = (r < 33) ? OP_INSERT : (r < 48) ? OP_FIND : (r < 60) ? OP_CHANGE :
                  (r < 78) ? OP_REMOVE : OP_READ;
    endcase
    // a few unused codes in every phase
    if ($urandom_range(0, 99) < 4) begin
      it.func = FUNC_W'($urandom_range(OP_READ + 1, OP_LAST_CODE));
    end
    return it;
  endfunction

  // present one transaction in bursts with random gaps; called at a falling edge
  task automatic issue(input in_item_t it);
    logic free;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    // busy is stable between the falling and the next rising edge
    forever begin
      free = !busy;
      @(negedge clk);
      if (free) break;
    end
    op_tally[it.func]++;
  endtask

  // hold off until every awaited reply has arrived
  task automatic drain_pause();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    burst_left    = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: read, find and remove all miss
    issue(mk(OP_READ,   '0,      '0, 4'd0));
    issue(mk(OP_FIND,   '0,      '0, 4'd0));
    issue(mk(OP_REMOVE, VAL_MIN, '0, 4'd0));
    // inserts at, inside and past the count, with a duplicate zero
    issue(mk(OP_INSERT, VAL_MIN, '0, 4'd15));
    issue(mk(OP_INSERT, VAL_MAX, '0, 4'd0));
    issue(mk(OP_INSERT, '0,      '0, 4'd1));
    issue(mk(OP_INSERT, -32'sd1, '0, 4'd3));
    issue(mk(OP_INSERT, '0,      '0, 4'd2));
    // searches: first of duplicates, last entry, miss
    issue(mk(OP_FIND, '0,         '0, 4'd0));
    issue(mk(OP_FIND, -32'sd1,    '0, 4'd0));
    issue(mk(OP_FIND, VAL_ABSENT, '0, 4'd0));
    // change to the same value, to a new value, and a miss
    issue(mk(OP_CHANGE, '0,         '0,            4'd0));
    issue(mk(OP_CHANGE, VAL_MIN,    32'h5555_5555, 4'd0));
    issue(mk(OP_CHANGE, VAL_ABSENT, VAL_MAX,       4'd0));
    // reads: first, last, just past the count, top index
    issue(mk(OP_READ, '0, '0, 4'd0));
    issue(mk(OP_READ, '0, '0, 4'd4));
    issue(mk(OP_READ, '0, '0, 4'd5));
    issue(mk(OP_READ, '0, '0, 4'd15));
    // removes: head entry, first of duplicates, miss
    issue(mk(OP_REMOVE, VAL_MAX,    '0, 4'd0));
    issue(mk(OP_REMOVE, '0,         '0, 4'd0));
    issue(mk(OP_REMOVE, VAL_ABSENT, '0, 4'd0));
    // unused codes with busy fields
    issue(mk(FUNC_W'(OP_READ + 1), VAL_MAX, VAL_MIN, 4'd15));
    issue(mk(OP_LAST_CODE, -32'sd1, -32'sd1, 4'd15));
    drain_pause();

    // random phases: fill to full, churn, drain toward empty
    for (int p = 0; p < PHASES; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) issue(random_item(phase_kind_t'(p % 3)));
      if (p == PHASES / 2) drain_pause();
    end

    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d insert, %0d find, %0d change, %0d remove, %0d read transactions",
             op_tally[OP_INSERT], op_tally[OP_FIND], op_tally[OP_CHANGE],
             op_tally[OP_REMOVE], op_tally[OP_READ]);
    $display("plus %0d with unused codes; %0d replies compared, %0d failures",
             op_tally[OP_READ + 1] + op_tally[OP_READ + 2] + op_tally[OP_LAST_CODE],
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
